@@ rtl/icov_pkg.sv @@
`timescale 1ns / 1ps

package icov_pkg;

    localparam int unsigned MAX_INTERVALS_DEF = 16;
    localparam int unsigned OFFSET_BITS_DEF   = 48;

endpackage

@@ rtl/icov_req_if.sv @@
`timescale 1ns / 1ps

interface icov_req_if #(
    parameter int unsigned OFFSET_BITS = icov_pkg::OFFSET_BITS_DEF
);

    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] start_ofs;
    logic [OFFSET_BITS-1:0] end_ofs;

    modport source (
        output valid,
        output start_ofs,
        output end_ofs,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_ofs,
        input  end_ofs,
        output ready
    );

endinterface

@@ rtl/icov_rsp_if.sv @@
`timescale 1ns / 1ps

interface icov_rsp_if #(
    parameter int unsigned OFFSET_BITS = icov_pkg::OFFSET_BITS_DEF
);

    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] contiguous_end;
    logic [OFFSET_BITS-1:0] highest_end;
    logic                   table_full_drop;

    modport source (
        output valid,
        output contiguous_end,
        output highest_end,
        output table_full_drop,
        input  ready
    );

    modport sink (
        input  valid,
        input  contiguous_end,
        input  highest_end,
        input  table_full_drop,
        output ready
    );

endinterface

@@ rtl/icov_ram.sv @@
`timescale 1ns / 1ps

module icov_ram #(
    parameter int unsigned DEPTH = 2 * icov_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned WIDTH = 2 * icov_pkg::OFFSET_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/interval_coverage_tracker_unit.sv @@
`timescale 1ns / 1ps
// channel | dir | payload                                          | handshake
// req     | in  | start_ofs, end_ofs                               | valid/ready
// rsp     | out | contiguous_end, highest_end, table_full_drop     | valid/ready
//
// a request walks the stored intervals in order: each entry is read from the ram
// in S_READ and then compared in S_PROC by a single merge/compare unit streaming
// into the opposite ram bank; S_FLUSH and S_DONE follow. req.ready returns
// together with the loaded result.
// req.ready is high only while idle; the next request is taken while a result
// still waits in the output register.
// rsp.valid holds with its payload until rsp.ready; a finished merge waits for it.
// rst_n empties the table at once; no clearing pass.

module interval_coverage_tracker_unit #(
    parameter int unsigned MAX_INTERVALS = icov_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned OFFSET_BITS   = icov_pkg::OFFSET_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    icov_req_if.sink   req,
    icov_rsp_if.source rsp
);

    localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned OUT_W = $clog2(MAX_INTERVALS + 2);
    localparam int unsigned ADR_W = IDX_W + 1;
    localparam int unsigned W     = OFFSET_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [W-1:0]     s_reg;
    logic [W-1:0]     e_reg;
    logic             placed_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [OUT_W-1:0] wr_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             bank_reg;
    logic [W-1:0]     cont_reg;
    logic [W-1:0]     high_reg;
    logic [W-1:0]     new_cont_reg;
    logic [W-1:0]     new_high_reg;
    logic             out_valid_reg;
    logic [W-1:0]     out_cont_reg;
    logic [W-1:0]     out_high_reg;
    logic             out_drop_reg;

    logic [2*W-1:0]   rd_data;
    logic [W-1:0]     rd_start;
    logic [W-1:0]     rd_end;
    logic             emit;
    logic [W-1:0]     emit_start;
    logic [W-1:0]     emit_end;
    logic             absorb;
    logic             advance;
    logic             place;
    logic             ram_we;
    logic             ram_re;
    logic [ADR_W-1:0] ram_waddr;
    logic [ADR_W-1:0] ram_raddr;
    logic             done_load;
    logic             drop;
    logic             req_fire;

    assign rd_start  = rd_data[2*W-1:W];
    assign rd_end    = rd_data[W-1:0];
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign done_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign drop      = (wr_idx_reg > OUT_W'(MAX_INTERVALS));

    assign ram_we    = emit && (wr_idx_reg < OUT_W'(MAX_INTERVALS));
    assign ram_waddr = {~bank_reg, wr_idx_reg[IDX_W-1:0]};
    assign ram_re    = (state_reg == S_READ) && (rd_idx_reg != count_reg);
    assign ram_raddr = {bank_reg, rd_idx_reg[IDX_W-1:0]};

    // merge unit: one stored entry against the pending interval
    always_comb
    begin
        emit       = 1'b0;
        emit_start = s_reg;
        emit_end   = e_reg;
        absorb     = 1'b0;
        advance    = 1'b0;
        place      = 1'b0;
        unique case (state_reg)
            S_PROC:
            begin
                priority if (placed_reg || (rd_end < s_reg))
                begin
                    emit       = 1'b1;
                    emit_start = rd_start;
                    emit_end   = rd_end;
                    advance    = 1'b1;
                end
                else if (rd_start <= e_reg)
                begin
                    absorb  = 1'b1;
                    advance = 1'b1;
                end
                else
                begin
                    emit  = 1'b1;
                    place = 1'b1;
                end
            end
            S_FLUSH:
            begin
                emit = !placed_reg;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    icov_ram #(
        .DEPTH (1 << ADR_W),
        .WIDTH (2 * W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({emit_start, emit_end}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            cont_reg      <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
            placed_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            s_reg         <= '0;
            e_reg         <= '0;
            new_cont_reg  <= '0;
            new_high_reg  <= '0;
            out_cont_reg  <= '0;
            out_high_reg  <= '0;
            out_drop_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                wr_idx_reg   <= wr_idx_reg + OUT_W'(1);
                new_high_reg <= emit_end;
                if (wr_idx_reg == '0)
                begin
                    new_cont_reg <= (emit_start == '0) ? emit_end : '0;
                end
            end

            if (rsp.valid && rsp.ready && !done_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        // swapped bounds are taken in order
                        if (req.start_ofs > req.end_ofs)
                        begin
                            s_reg <= req.end_ofs;
                            e_reg <= req.start_ofs;
                        end
                        else
                        begin
                            s_reg <= req.start_ofs;
                            e_reg <= req.end_ofs;
                        end
                        placed_reg <= 1'b0;
                        rd_idx_reg <= '0;
                        wr_idx_reg <= '0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= (rd_idx_reg == count_reg) ? S_FLUSH : S_PROC;
                end
                S_PROC:
                begin
                    if (absorb)
                    begin
                        s_reg <= (rd_start < s_reg) ? rd_start : s_reg;
                        e_reg <= (rd_end > e_reg) ? rd_end : e_reg;
                    end
                    if (place)
                    begin
                        placed_reg <= 1'b1;
                    end
                    if (advance)
                    begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                        state_reg  <= S_READ;
                    end
                end
                S_FLUSH:
                begin
                    placed_reg <= 1'b1;
                    state_reg  <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_drop_reg  <= drop;
                        if (drop)
                        begin
                            out_cont_reg <= cont_reg;
                            out_high_reg <= high_reg;
                        end
                        else
                        begin
                            out_cont_reg <= new_cont_reg;
                            out_high_reg <= new_high_reg;
                            cont_reg     <= new_cont_reg;
                            high_reg     <= new_high_reg;
                            count_reg    <= wr_idx_reg[CNT_W-1:0];
                            bank_reg     <= ~bank_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.contiguous_end  = out_cont_reg;
    assign rsp.highest_end     = out_high_reg;
    assign rsp.table_full_drop = out_drop_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_INTERVALS))
        else $error("interval count above table size");

    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= OUT_W'(MAX_INTERVALS + 1))
        else $error("merge output index overran");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_load && drop) |-> (count_reg == CNT_W'(MAX_INTERVALS)))
        else $error("drop with free table slot");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request taken while merge in progress");

endmodule
